FILE: src/sud_pkg.sv
// shared types and constants for the pipelined 32-bit signed/unsigned divider
// no dependencies
`timescale 1ns / 1ps

package sud_pkg;

    localparam int WORD_W  = 32;
    // one prep stage, one stage per quotient bit, one fix-up stage
    localparam int LATENCY = WORD_W + 2;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic {
        CMD_UNSIGNED = 1'b0,
        CMD_SIGNED   = 1'b1
    } cmd_t;

    // payload carried from stage to stage next to its valid bit
    typedef struct packed {
        word_t rem;   // partial remainder
        word_t nq;    // dividend bits still to shift out, quotient bits shifted in
        word_t dvs;   // divisor magnitude
        logic  neg;   // quotient must be negated at the end
        logic  dz;    // divisor was zero
    } sud_pipe_t;

endpackage

FILE: src/sud_prep.sv
// entry stage: operand magnitudes, result sign and zero-divisor flag
// depends on sud_pkg
`timescale 1ns / 1ps

module sud_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cmd,
    input  sud_pkg::word_t    dividend,
    input  sud_pkg::word_t    divisor,
    output logic              out_valid,
    output sud_pkg::sud_pipe_t out_data
);
    import sud_pkg::*;

    logic      valid_reg;
    sud_pipe_t data_reg;
    sud_pipe_t data_next;
    logic      is_signed;

    assign is_signed = (cmd == CMD_SIGNED);

    always_comb
    begin
        data_next.rem = '0;
        data_next.nq  = (is_signed && dividend[WORD_W-1]) ? (~dividend + 1'b1) : dividend;
        data_next.dvs = (is_signed && divisor[WORD_W-1]) ? (~divisor + 1'b1) : divisor;
        data_next.neg = is_signed && (dividend[WORD_W-1] ^ divisor[WORD_W-1]);
        data_next.dz  = (divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_unsigned_not_negated: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && (cmd == CMD_UNSIGNED) |=> !data_reg.neg)
        else $error("unsigned word marked for negation");

endmodule

FILE: src/sud_stage.sv
// one restoring division step: produces one quotient bit per stage
// depends on sud_pkg
`timescale 1ns / 1ps

module sud_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sud_pkg::sud_pipe_t in_data,
    output logic               out_valid,
    output sud_pkg::sud_pipe_t out_data
);
    import sud_pkg::*;

    logic              valid_reg;
    sud_pipe_t         data_reg;
    sud_pipe_t         data_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;
    logic              fits;

    assign shifted = {in_data.rem, in_data.nq[WORD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, in_data.dvs};
    assign fits    = !diff[WORD_W+1];

    always_comb
    begin
        data_next     = in_data;
        // remainder stays below the divisor, so the low word holds it
        data_next.rem = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
        data_next.nq  = {in_data.nq[WORD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && (in_data.dvs != '0) && (in_data.rem < in_data.dvs)
        |=> data_reg.rem < data_reg.dvs)
        else $error("partial remainder not below divisor");

endmodule

FILE: src/sud_fix.sv
// exit stage: applies the result sign and forces zero on a zero divisor
// depends on sud_pkg
`timescale 1ns / 1ps

module sud_fix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sud_pkg::sud_pipe_t in_data,
    output logic               done,
    output sud_pkg::word_t     quotient
);
    import sud_pkg::*;

    logic  done_reg;
    word_t quotient_reg;
    word_t quotient_next;

    always_comb
    begin
        if (in_data.dz)
        begin
            quotient_next = '0;
        end
        else if (in_data.neg)
        begin
            quotient_next = ~in_data.nq + 1'b1;
        end
        else
        begin
            quotient_next = in_data.nq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        quotient_reg <= quotient_next;
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

    a_zero_divisor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_data.dz |=> quotient_reg == '0)
        else $error("zero divisor gave a nonzero quotient");

endmodule

FILE: src/signed_unsigned_divider_32.sv
// pipelined 32-bit signed/unsigned divider, quotient only
// path from accept to done: prep stage, 32 one-bit restoring stages, fix-up
// throughput: one word per cycle once busy is low after reset; the depth is set by one quotient bit per stage
// reset: clears every stage valid bit; busy is high in reset and the first cycle after
// results appear on done/quotient for one cycle and cannot be stalled
`timescale 1ns / 1ps

module signed_unsigned_divider_32 (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic           cmd,
    input  sud_pkg::word_t dividend,
    input  sud_pkg::word_t divisor,
    output logic           done,
    output sud_pkg::word_t quotient
);
    import sud_pkg::*;

    logic      busy_reg;
    logic      accept;
    logic      pipe_valid [0:WORD_W];
    sud_pipe_t pipe_data  [0:WORD_W];

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    sud_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cmd       (cmd),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (pipe_valid[0]),
        .out_data  (pipe_data[0])
    );

    for (genvar i = 0; i < WORD_W; i++)
    begin : g_step
        sud_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    sud_fix u_fix (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pipe_valid[WORD_W]),
        .in_data  (pipe_data[WORD_W]),
        .done     (done),
        .quotient (quotient)
    );

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy, LATENCY))
        else $error("done does not match accepted word");

    a_zero_divisor_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(divisor, LATENCY) == '0) |-> quotient == '0)
        else $error("zero divisor result not zero");

    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose again after reset");

endmodule

FILE: sim/tb_signed_unsigned_divider_32.sv
// self-checking testbench for signed_unsigned_divider_32: directed table then random words,
// each quotient checked against a known answer or an in-bench divider model; depends on src/sud_pkg.sv
`timescale 1ns / 1ps

module tb_signed_unsigned_divider_32;

    import sud_pkg::*;

    localparam int NUM_RANDOM = 1300;
    localparam int MAX_GAP    = 2;
    localparam int MAX_CYCLES = 200000;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        cmd_t  op;
        word_t n;
        word_t d;
        logic  typed;   // quotient below is the known answer
        word_t q;
    } div_case_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    cmd_t  cmd = CMD_UNSIGNED;
    word_t dividend = '0;
    word_t divisor = '0;
    logic  busy;
    logic  done;
    word_t quotient;

    // known answer travels with the word so the checker can pick it up at accept
    logic  cur_typed = 1'b0;
    word_t cur_q = '0;

    word_t     pending_quotients[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    div_case_t dir_cases [21];

    signed_unsigned_divider_32 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic word_t quotient_of(cmd_t op, word_t n, word_t d);
        word_t n_mag;
        word_t d_mag;
        word_t q;
        if (d == '0)
            return '0;
        if (op == CMD_UNSIGNED)
            return n / d;
        n_mag = n[WORD_W-1] ? -n : n;
        d_mag = d[WORD_W-1] ? -d : d;
        q = n_mag / d_mag;
        // negative quotient when operand signs differ; most negative by minus one wraps
        return (n[WORD_W-1] ^ d[WORD_W-1]) ? -q : q;
    endfunction

    always @(posedge clk)
    begin
        word_t exp_q;
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("tb_signed_unsigned_divider_32 NOT OK");
            $finish;
        end
        if (rst_n && start && !busy)
            pending_quotients.push_back(cur_typed ? cur_q : quotient_of(cmd, dividend, divisor));
        if (rst_n && done)
        begin
            if (pending_quotients.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < MAX_REPORT)
                    $display("unexpected word: quotient %h", quotient);
            end
            else
            begin
                exp_q = pending_quotients.pop_front();
                if (quotient !== exp_q)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORT)
                        $display("quotient mismatch: expected %h got %h", exp_q, quotient);
                end
            end
        end
    end

    task automatic send_word(cmd_t op, word_t n, word_t d, logic typed, word_t q, bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 33)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        start     <= 1'b1;
        cmd       <= op;
        dividend  <= n;
        divisor   <= d;
        cur_typed <= typed;
        cur_q     <= q;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        cmd_t  op;
        word_t n;
        word_t d;
        int    pick;

        dir_cases = '{
            // zero divisor in both modes
            '{CMD_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{CMD_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{CMD_SIGNED,   32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{CMD_SIGNED,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
            // most negative by minus one wraps, then other extreme operand pairs in both modes
            '{CMD_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
            '{CMD_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
            '{CMD_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
            '{CMD_UNSIGNED, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
            '{CMD_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
            '{CMD_SIGNED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
            '{CMD_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0001},
            '{CMD_SIGNED,   32'h8000_0000, 32'h0000_0001, 1'b1, 32'h8000_0000},
            '{CMD_SIGNED,   32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0001},
            '{CMD_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000},
            // truncation toward zero over the sign combinations, then two unsigned words
            '{CMD_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, 1'b0, 32'h0},
            '{CMD_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, 1'b0, 32'h0},
            '{CMD_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, 32'h0},
            '{CMD_SIGNED,   32'h8000_0001, 32'h0000_0002, 1'b0, 32'h0},
            '{CMD_SIGNED,   32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
            '{CMD_UNSIGNED, 32'h1234_5678, 32'h0000_0010, 1'b0, 32'h0},
            '{CMD_UNSIGNED, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_cases[i])
            send_word(dir_cases[i].op, dir_cases[i].n, dir_cases[i].d,
                      dir_cases[i].typed, dir_cases[i].q, 1'b1);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            op = cmd_t'($urandom_range(0, 1));

            pick = $urandom_range(0, 9);
            if (pick == 0)
                d = '0;
            else if (pick == 1)
            begin
                case ($urandom_range(0, 2))
                    0: d = 32'hFFFF_FFFF;
                    1: d = 32'h0000_0001;
                    default: d = 32'h8000_0000;
                endcase
            end
            else if (pick <= 4)
            begin
                d = $urandom_range(1, 255);
                if ($urandom_range(0, 1) == 1)
                    d = -d;
            end
            else
                d = $urandom >> $urandom_range(0, 31);

            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                case ($urandom_range(0, 3))
                    0: n = 32'h0000_0000;
                    1: n = 32'h8000_0000;
                    2: n = 32'h7FFF_FFFF;
                    default: n = 32'hFFFF_FFFF;
                endcase
            end
            else if (pick <= 3)
            begin
                // vary the magnitude so quotients of every length show up
                n = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    n = -n;
            end
            else
                n = $urandom;

            // back-to-back stretch with no gaps at all
            send_word(op, n, d, 1'b0, '0, !(i >= 500 && i < 800));
        end
        start <= 1'b0;

        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_signed_unsigned_divider_32 OK");
        else
            $display("tb_signed_unsigned_divider_32 NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
src/sud_pkg.sv
src/sud_prep.sv
src/sud_stage.sv
src/sud_fix.sv
src/signed_unsigned_divider_32.sv
sim/tb_signed_unsigned_divider_32.sv
